>>> design/oht_pkg.sv
package oht_pkg;

   localparam int BINS       = 256;
   localparam int BIN_W      = 8;
   localparam int MAX_PIXELS = 4194304;
   localparam int CNT_W      = 23;
   localparam int SUM_W      = 31;
   localparam int TC_W       = BIN_W + CNT_W;
   localparam int AB_W       = SUM_W + CNT_W;
   localparam int W_W        = 2 * CNT_W;
   localparam int D2_W       = 2 * AB_W;
   localparam int PROD_W     = D2_W + W_W;
   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = 2;
   localparam int QCNT_W     = 3;

   localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(BINS - 1);
   localparam logic [CNT_W-1:0] PIX_MAX  = CNT_W'(MAX_PIXELS);

   // classified pixel handed from the front to the back
   typedef struct packed {
      logic [BIN_W-1:0] pixel;
      logic             count;
      logic             last;
   } q_item_type;

   // back status seen by the front
   typedef struct packed {
      logic init_busy;
   } back_status_type;

   typedef enum logic [3:0] {
      ST_CLR,
      ST_RUN,
      ST_DRAIN,
      ST_RD,
      ST_ACC,
      ST_CHK,
      ST_MUL,
      ST_DIFF,
      ST_SQ,
      ST_SQD,
      ST_LM,
      ST_RM,
      ST_NEXT,
      ST_DONE
   } back_state_type;

endpackage

>>> design/oht_ram.sv
module oht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write, and read the old contents
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/oht_front.sv
module oht_front import oht_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic [BIN_W-1:0] req_pixel,
   input  logic             req_last,
   output logic             req_full,
   input  back_status_type  status,
   output q_item_type       item,
   output logic             item_valid,
   input  logic             item_pop
);

   q_item_type        queue_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0]  seen_ff, seen_in;
   logic              accept;
   logic              take;
   q_item_type        new_item;

   assign req_full   = (fill_ff == QCNT_W'(QDEPTH)) || status.init_busy;
   assign accept     = req_push && !req_full;
   assign item_valid = (fill_ff != '0);
   assign take       = item_pop && item_valid;
   assign item       = queue_ff[rd_ptr_ff];

   // classify: saturate the grey level, stop counting at the frame limit
   always_comb begin
      new_item.pixel = (req_pixel > BIN_LAST) ? BIN_LAST : req_pixel;
      new_item.count = (seen_ff < PIX_MAX);
      new_item.last  = req_last;
      seen_in        = seen_ff;
      if (accept) begin
         if (req_last) begin
            seen_in = '0;
         end else if (new_item.count) begin
            seen_in = seen_ff + CNT_W'(1);
         end
      end
   end

   // advance queue pointers
   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + QCNT_W'(accept) - QCNT_W'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         seen_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
         seen_ff   <= seen_in;
      end
   end

   // hold queued transactions
   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

>>> design/oht_back.sv
module oht_back import oht_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  q_item_type       item,
   input  logic             item_valid,
   output logic             item_pop,
   output back_status_type  status,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [BIN_W-1:0] rsp_level,
   output logic             rsp_found
);

   back_state_type    state_ff, state_in;
   logic [BIN_W-1:0]  t_ff, t_in;
   logic              init_ff, init_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              s1_valid_ff, s1_valid_in;
   logic [BIN_W-1:0]  s1_px_ff, s1_px_in;
   logic              fw_valid_ff;
   logic [BIN_W-1:0]  fw_addr_ff;
   logic [CNT_W-1:0]  fw_data_ff;
   logic [CNT_W-1:0]  wb_ff, wb_in;
   logic [TC_W-1:0]   tc_ff, tc_in;
   logic [SUM_W-1:0]  sumb_ff, sumb_in;
   logic [CNT_W-1:0]  wf_ff, wf_in;
   logic [AB_W-1:0]   a_ff, a_in;
   logic [AB_W-1:0]   b_ff, b_in;
   logic [W_W-1:0]    w_ff, w_in;
   logic [D2_W-1:0]   d2_ff, d2_in;
   logic [PROD_W-1:0] mcand_ff, mcand_in;
   logic [AB_W-1:0]   mplier_ff, mplier_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [PROD_W-1:0] lhs_ff, lhs_in;
   logic              found_ff, found_in;
   logic [D2_W-1:0]   bd2_ff, bd2_in;
   logic [W_W-1:0]    bw_ff, bw_in;
   logic [BIN_W-1:0]  bt_ff, bt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BIN_W-1:0]  rsp_level_ff, rsp_level_in;
   logic              rsp_found_ff, rsp_found_in;

   logic              ram_we;
   logic [BIN_W-1:0]  ram_waddr;
   logic [CNT_W-1:0]  ram_wdata;
   logic [BIN_W-1:0]  ram_raddr;
   logic [CNT_W-1:0]  ram_rdata;
   logic [CNT_W-1:0]  cur_count;
   logic [CNT_W-1:0]  inc_count;
   logic [AB_W-1:0]   diff;
   logic              mul_done;

   oht_ram #(
      .WIDTH (CNT_W),
      .DEPTH (BINS)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign status.init_busy = init_ff;
   assign rsp_empty        = !rsp_valid_ff;
   assign rsp_level        = rsp_level_ff;
   assign rsp_found        = rsp_found_ff;

   // bypass a count written in the cycle its read was issued
   assign cur_count = (fw_valid_ff && (fw_addr_ff == s1_px_ff)) ? fw_data_ff : ram_rdata;
   assign inc_count = cur_count + CNT_W'(1);
   assign diff      = (a_ff > b_ff) ? a_ff - b_ff : b_ff - a_ff;
   assign mul_done  = (mplier_ff == '0);

   // histogram write port: increment stage first, then scan and clear sweeps
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = t_ff;
      ram_wdata = '0;
      if (s1_valid_ff) begin
         ram_we    = 1'b1;
         ram_waddr = s1_px_ff;
         ram_wdata = inc_count;
      end else if (state_ff == ST_RD || state_ff == ST_CLR) begin
         ram_we = 1'b1;
      end
   end

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      t_in         = t_ff;
      init_in      = init_ff;
      total_in     = total_ff;
      sum_in       = sum_ff;
      s1_valid_in  = 1'b0;
      s1_px_in     = item.pixel;
      wb_in        = wb_ff;
      tc_in        = tc_ff;
      sumb_in      = sumb_ff;
      wf_in        = wf_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      w_in         = w_ff;
      d2_in        = d2_ff;
      mcand_in     = mcand_ff << 1;
      mplier_in    = mplier_ff >> 1;
      prod_in      = mplier_ff[0] ? prod_ff + mcand_ff : prod_ff;
      lhs_in       = lhs_ff;
      found_in     = found_ff;
      bd2_in       = bd2_ff;
      bw_in        = bw_ff;
      bt_in        = bt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_level_in = rsp_level_ff;
      rsp_found_in = rsp_found_ff;
      item_pop     = 1'b0;
      ram_raddr    = t_ff;

      case (state_ff)
         ST_CLR: begin
            if (t_ff == BIN_LAST) begin
               init_in  = 1'b0;
               state_in = ST_RUN;
            end else begin
               t_in = t_ff + BIN_W'(1);
            end
         end
         ST_RUN: begin
            ram_raddr = item.pixel;
            if (item_valid) begin
               item_pop = 1'b1;
               if (item.count) begin
                  s1_valid_in = 1'b1;
                  total_in    = total_ff + CNT_W'(1);
                  sum_in      = sum_ff + SUM_W'(item.pixel);
               end
               if (item.last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            t_in     = '0;
            wb_in    = '0;
            sumb_in  = '0;
            found_in = 1'b0;
            state_in = ST_RD;
         end
         ST_RD: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            wb_in    = wb_ff + ram_rdata;
            tc_in    = TC_W'(t_ff) * TC_W'(ram_rdata);
            state_in = ST_CHK;
         end
         ST_CHK: begin
            sumb_in = sumb_ff + SUM_W'(tc_ff);
            wf_in   = total_ff - wb_ff;
            if (wb_ff == '0) begin
               state_in = ST_NEXT;
            end else if (wb_ff == total_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            a_in     = AB_W'(sumb_ff) * AB_W'(total_ff);
            b_in     = AB_W'(sum_ff) * AB_W'(wb_ff);
            w_in     = W_W'(wb_ff) * W_W'(wf_ff);
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            if (a_ff == b_ff) begin
               state_in = ST_NEXT;
            end else begin
               mcand_in  = PROD_W'(diff);
               mplier_in = diff;
               prod_in   = '0;
               state_in  = ST_SQ;
            end
         end
         ST_SQ: begin
            if (mul_done) begin
               d2_in    = prod_ff[D2_W-1:0];
               state_in = ST_SQD;
            end
         end
         ST_SQD: begin
            if (!found_ff) begin
               found_in = 1'b1;
               bd2_in   = d2_ff;
               bw_in    = w_ff;
               bt_in    = t_ff;
               state_in = ST_NEXT;
            end else begin
               mcand_in  = PROD_W'(d2_ff);
               mplier_in = AB_W'(bw_ff);
               prod_in   = '0;
               state_in  = ST_LM;
            end
         end
         ST_LM: begin
            if (mul_done) begin
               lhs_in    = prod_ff;
               mcand_in  = PROD_W'(bd2_ff);
               mplier_in = AB_W'(w_ff);
               prod_in   = '0;
               state_in  = ST_RM;
            end
         end
         ST_RM: begin
            if (mul_done) begin
               if (lhs_ff > prod_ff) begin
                  bd2_in = d2_ff;
                  bw_in  = w_ff;
                  bt_in  = t_ff;
               end
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (t_ff == BIN_LAST) begin
               state_in = ST_DONE;
            end else begin
               t_in     = t_ff + BIN_W'(1);
               state_in = ST_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = found_ff ? bt_ff : '0;
               rsp_found_in = found_ff;
               total_in     = '0;
               sum_in       = '0;
               if (t_ff == BIN_LAST) begin
                  state_in = ST_RUN;
               end else begin
                  t_in     = t_ff + BIN_W'(1);
                  state_in = ST_CLR;
               end
            end
         end
         default: begin
            state_in = ST_CLR;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         t_ff         <= '0;
         init_ff      <= 1'b1;
         total_ff     <= '0;
         sum_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         fw_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         t_ff         <= t_in;
         init_ff      <= init_in;
         total_ff     <= total_in;
         sum_ff       <= sum_in;
         s1_valid_ff  <= s1_valid_in;
         fw_valid_ff  <= s1_valid_ff;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_px_ff     <= s1_px_in;
      fw_addr_ff   <= s1_px_ff;
      fw_data_ff   <= inc_count;
      wb_ff        <= wb_in;
      tc_ff        <= tc_in;
      sumb_ff      <= sumb_in;
      wf_ff        <= wf_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      w_ff         <= w_in;
      d2_ff        <= d2_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      prod_ff      <= prod_in;
      lhs_ff       <= lhs_in;
      bd2_ff       <= bd2_in;
      bw_ff        <= bw_in;
      bt_ff        <= bt_in;
      rsp_level_ff <= rsp_level_in;
      rsp_found_ff <= rsp_found_in;
   end

endmodule

>>> design/otsu_histogram_threshold.sv
// Otsu threshold of 8-bit frames.
// Input channel: push a pixel with req_pixel and req_last (final pixel of
// the frame) while req_full is low. Pixels are taken one per cycle into a
// four-entry queue and counted into a 256-bin histogram RAM at one per
// cycle outside scan and clear. Result channel: one transaction per frame,
// rsp_level and rsp_found, shown while rsp_empty is low, taken with rsp_pop.
// After the last pixel the back end scans the bins one at a time. A bin that
// is skipped steps through read, accumulate, check and next; a candidate bin
// also runs a shift-add multiplier until its multiplier operand is zero,
// once for the squared difference if it is nonzero and, once a best bin is
// held, for the two cross products compared against it; bins left after the
// scan stops are cleared at one per cycle.
// Pixels of the next frame queue up during the scan; req_full rises once the
// queue holds four.
// After reset all 256 bins are cleared in one pass with req_full high.
// If the result is not popped, the finished result waits in the output
// register and the scan of the next frame stalls before its own result.
module otsu_histogram_threshold import oht_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic [BIN_W-1:0] req_pixel,
   input  logic             req_last,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [BIN_W-1:0] rsp_level,
   output logic             rsp_found
);

   q_item_type      item;
   logic            item_valid;
   logic            item_pop;
   back_status_type status;

   oht_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_pixel  (req_pixel),
      .req_last   (req_last),
      .req_full   (req_full),
      .status     (status),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop)
   );

   oht_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .status     (status),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_level  (rsp_level),
      .rsp_found  (rsp_found)
   );

endmodule
